[design/vertex_dedup_hash_table_core_macros.svh]
// Assertion macros for the vertex dedup hash table core.
// Used by design/vertex_dedup_hash_table_core.sv; needs clk_i and rst_ni in scope.
`ifndef VERTEX_DEDUP_HASH_TABLE_CORE_MACROS_SVH
`define VERTEX_DEDUP_HASH_TABLE_CORE_MACROS_SVH

// checked only outside reset
`define VDHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define VDHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/vdht_pkg.sv]
// Package for the vertex dedup hash table: item structs, codes, hash constants.
// No dependencies; imported by vertex_dedup_hash_table_core.
`default_nettype none

package vdht_pkg;

  localparam int unsigned BucketsDef    = 1024;
  localparam int unsigned MaxEntriesDef = 4096;

  localparam logic [31:0] HashInit = 32'h811C_9DC5;
  localparam logic [31:0] HashMul  = 32'h9E37_79B1;

  localparam logic [1:0] FuncClear  = 2'd0;
  localparam logic [1:0] FuncInsert = 2'd1;
  localparam logic [1:0] FuncLookup = 2'd2;

  localparam logic [2:0] StFound    = 3'd0;
  localparam logic [2:0] StAdded    = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StCleared  = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] vertex_index;
    logic [12:0] unique_count;
  } out_item_t;

  function automatic logic [31:0] norm_word(input logic [31:0] w);
    norm_word = (w[30:0] == 31'd0) ? 32'd0 : w;
  endfunction

  function automatic logic word_eq(input logic [31:0] a, input logic [31:0] b);
    logic nan_a;
    logic nan_b;
    nan_a = (a[30:0] > 31'h7F80_0000);
    nan_b = (b[30:0] > 31'h7F80_0000);
    word_eq = !nan_a && !nan_b && (norm_word(a) == norm_word(b));
  endfunction

endpackage

`default_nettype wire

[design/vertex_dedup_hash_table_core.sv]
// Vertex dedup hash table, one item at a time. An insert or lookup hashes the vertex one
// word at a time (one multiply per word), reduces the hash to a bucket by a reciprocal
// multiply (quotient, then remainder), reads the bucket head, then walks the chain one
// entry at a time. A lookup miss reports not found, and an insert miss appends the vertex
// and links it into the chain if room is left. A stalled output holds the block in its
// result state, and the next item is taken at the edge after the result is loaded. A clear
// sweeps the whole bucket-head memory, and after reset the same sweep runs before the first
// item is taken. Depends on vdht_pkg and vertex_dedup_hash_table_core_macros.svh.
`default_nettype none

`include "vertex_dedup_hash_table_core_macros.svh"

module vertex_dedup_hash_table_core
  import vdht_pkg::*;
#(
  parameter int unsigned BUCKETS     = BucketsDef,
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned IW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned DW = IW + 160;
  localparam logic [IW-1:0] Nil     = IW'(MAX_ENTRIES);
  localparam logic [BW-1:0] BktLast = BW'(BUCKETS - 1);
  localparam logic [32:0]   RecipM  = 33'((64'd1 << (32 + BW)) / 64'(BUCKETS) + 64'd1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_HASH = 4'd2;
  localparam logic [3:0] S_MOD  = 4'd3;
  localparam logic [3:0] S_HEAD = 4'd4;
  localparam logic [3:0] S_HLD  = 4'd5;
  localparam logic [3:0] S_WALK = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_LINK = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic          emit_q, emit_d;
  logic [BW-1:0] clr_q, clr_d;
  logic [2:0]    k_q, k_d;
  logic [31:0]   p_q, p_d;
  logic [31:0]   quo_q, quo_d;
  logic [BW-1:0] b_q, b_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [159:0]  tdat_q, tdat_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [2:0]    st_q, st_d;
  logic [1:0]    func_q, func_d;
  logic [159:0]  w_q, w_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic [IW-1:0] head_mem [BUCKETS];
  logic [IW-1:0] head_rdata_q;
  logic          head_we;
  logic [BW-1:0] head_waddr;
  logic [IW-1:0] head_wdata;

  logic [DW-1:0] ent_mem [MAX_ENTRIES];
  logic [DW-1:0] ent_rdata_q;
  logic          ent_we;
  logic [AW-1:0] ent_waddr;
  logic [DW-1:0] ent_wdata;

  logic [31:0]   hv;
  logic [31:0]   mix;
  logic [31:0]   word_k;
  logic [64:0]   qprod;
  logic [BW-1:0] rem;
  logic          match;

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rdata_q <= head_mem[b_q];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_q <= ent_mem[cur_q[AW-1:0]];
  end

  assign hv  = p_q ^ (p_q >> 15);
  assign mix = (k_q == 3'd0) ? HashInit : hv;

  always_comb begin
    case (k_q)
      3'd0:    word_k = w_q[159:128];
      3'd1:    word_k = w_q[127:96];
      3'd2:    word_k = w_q[95:64];
      3'd3:    word_k = w_q[63:32];
      default: word_k = w_q[31:0];
    endcase
  end

  // hv mod BUCKETS: quotient by reciprocal multiply, then remainder
  assign qprod = 65'(hv) * 65'(RecipM);
  assign rem   = BW'(hv - quo_q * 32'(BUCKETS));

  assign match = word_eq(ent_rdata_q[159:128], w_q[159:128]) &&
                 word_eq(ent_rdata_q[127:96], w_q[127:96]) &&
                 word_eq(ent_rdata_q[95:64], w_q[95:64]) &&
                 word_eq(ent_rdata_q[63:32], w_q[63:32]) &&
                 word_eq(ent_rdata_q[31:0], w_q[31:0]);

  always_comb begin
    state_d     = state_q;
    emit_d      = emit_q;
    clr_d       = clr_q;
    k_d         = k_q;
    p_d         = p_q;
    quo_d       = quo_q;
    b_d         = b_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    tail_d      = tail_q;
    tdat_d      = tdat_q;
    idx_d       = idx_q;
    st_d        = st_q;
    func_d      = func_q;
    w_d         = w_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    head_we     = 1'b0;
    head_waddr  = clr_q;
    head_wdata  = Nil;
    ent_we      = 1'b0;
    ent_waddr   = cnt_q[AW-1:0];
    ent_wdata   = {Nil, w_q};
    in_ready_o  = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = in_item_i.func;
          w_d    = {in_item_i.pos_x, in_item_i.pos_y, in_item_i.pos_z,
                    in_item_i.tex_u, in_item_i.tex_v};
          k_d    = 3'd0;
          b_d    = '0;
          case (in_item_i.func)
            FuncClear: begin
              clr_d   = '0;
              emit_d  = 1'b1;
              cnt_d   = '0;
              st_d    = StCleared;
              idx_d   = '0;
              state_d = S_CLR;
            end
            FuncInsert, FuncLookup: begin
              state_d = S_HASH;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CLR: begin
        head_we = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == BktLast) begin
          state_d = emit_q ? S_OUT : S_IDLE;
        end
      end
      S_HASH: begin
        p_d = (mix ^ norm_word(word_k)) * HashMul;
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          k_d     = 3'd0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        k_d = k_q + 3'd1;
        if (k_q == 3'd0) begin
          quo_d = 32'(qprod >> (32 + BW));
        end else begin
          b_d     = rem;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        state_d = S_HLD;
      end
      S_HLD: begin
        cur_d   = head_rdata_q;
        tail_d  = Nil;
        state_d = S_WALK;
      end
      S_WALK: begin
        idx_d = '0;
        if (cur_q < cnt_q) begin
          state_d = S_CMP;
        end else if (func_q == FuncLookup) begin
          st_d    = StNotFound;
          state_d = S_OUT;
        end else if (cnt_q == Nil) begin
          st_d    = StFull;
          state_d = S_OUT;
        end else begin
          ent_we  = 1'b1;
          idx_d   = cnt_q;
          cnt_d   = cnt_q + 1'b1;
          st_d    = StAdded;
          state_d = S_LINK;
        end
      end
      S_CMP: begin
        if (match) begin
          st_d    = StFound;
          idx_d   = cur_q;
          state_d = S_OUT;
        end else begin
          tail_d  = cur_q;
          tdat_d  = ent_rdata_q[159:0];
          cur_d   = ent_rdata_q[DW-1:160];
          state_d = S_WALK;
        end
      end
      S_LINK: begin
        if (tail_q != Nil) begin
          ent_we    = 1'b1;
          ent_waddr = tail_q[AW-1:0];
          ent_wdata = {idx_q, tdat_q};
        end else begin
          head_we    = 1'b1;
          head_waddr = b_q;
          head_wdata = idx_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.status       = st_q;
          out_d.vertex_index = 12'(idx_q);
          out_d.unique_count = 13'(cnt_q);
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      emit_q      <= 1'b0;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_q      <= emit_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    p_q    <= p_d;
    quo_q  <= quo_d;
    b_q    <= b_d;
    cur_q  <= cur_d;
    tail_q <= tail_d;
    tdat_q <= tdat_d;
    idx_q  <= idx_d;
    st_q   <= st_d;
    func_q <= func_d;
    w_q    <= w_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `VDHT_ASSERT(a_cnt_bound, cnt_q <= Nil, "entry count above capacity")
  `VDHT_ASSERT(a_chain_order, (state_q == S_CMP && tail_q != Nil) |-> tail_q < cur_q, "chain not ascending")
  `VDHT_ASSERT(a_added_idx, (out_valid_o && out_item_o.status == StAdded) |-> out_item_o.unique_count == 13'(out_item_o.vertex_index) + 13'd1, "added index not last")
  `VDHT_ASSERT(a_cleared_cnt, (out_valid_o && out_item_o.status == StCleared) |-> out_item_o.unique_count == 13'd0, "clear left entries")
  `VDHT_ASSERT(a_link_after_add, (state_q == S_LINK) |-> (cnt_q != '0 && $past(state_q) == S_WALK), "link without append")

endmodule

`default_nettype wire
